[hw/rtl/ccal_pkg.sv]
`default_nettype none

package ccal_pkg;

  // Operation codes carried on the slave side's tuser.
  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_SET_TIME  = 2'd1,
    OP_SET_DATE  = 2'd2,
    OP_SET_ALARM = 2'd3
  } op_e;

  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam logic [5:0] LAST_MINUTE = 6'd59;
  localparam logic [4:0] LAST_HOUR   = 5'd23;
  localparam logic [3:0] LAST_MONTH  = 4'd11;

  localparam int unsigned DATA_W = 48;

  // Multiplicative inverse of 25 modulo 2**14. A 14-bit y is a multiple of 25
  // exactly when y * INV25 (mod 2**14) is no more than (2**14 - 1) / 25.
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  // Input item fields held in the input register.
  typedef struct packed {
    op_e         op;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic        alarm_enable;
  } in_item_t;

  // Gregorian rule: divisible by 4, and either not by 100 or by 400.
  // With a factor of 4 present, 100 | y is 25 | y and 400 | y is 16 | y plus 25 | y.
  function automatic logic is_leap(logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] days_in(logic [3:0] month, logic leap);
    logic [4:0] len;
    unique case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/clock_calendar_with_alarm.sv]
`default_nettype none

// Path: a beat accepted is held in the input register, processed once the result
//   register can take it, and shown on the master side from then on.
// Throughput: one beat per cycle unless the master stalls; the only state loop is
//   the counter and alarm update between the input register and the result register.
// Reset (rst_ni low, asynchronous): time 00:00:00.0, January 1st 2018, alarm off.
module clock_calendar_with_alarm #(
  parameter int TOP_YEAR         = 9999,
  parameter int TICKS_PER_SECOND = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Slave side: one operation per beat.
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata fields from bit 0 up: hour_in[4:0], minute_in[10:5], second_in[16:11],
  // day_in[21:17], month_in[25:22], year_in[39:26], alarm_enable[40], zero pad.
  input  wire logic [ccal_pkg::DATA_W-1:0]  s_axis_tdata,
  // tuser fields: operation[1:0].
  input  wire logic [1:0]                   s_axis_tuser,
  // Master side: one result per operation.
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // tdata fields from bit 0 up: accepted[0], alarm_fired[1], alarm_armed[2],
  // tenths_now[6:3], second_now[12:7], minute_now[18:13], hour_now[23:19],
  // day_now[28:24], month_now[32:29], year_now[46:33], zero pad[47].
  output logic [ccal_pkg::DATA_W-1:0]       m_axis_tdata
);
  import ccal_pkg::*;

  localparam logic [13:0] TopYear  = 14'(TOP_YEAR);
  localparam logic [3:0]  LastTick = 4'(TICKS_PER_SECOND - 1);

  // Input register and result register with their valid flags.
  in_item_t            in_q;
  logic                in_valid_q, in_valid_d;
  logic [DATA_W-1:0]   out_q, out_d;
  logic                out_valid_q, out_valid_d;

  // Clock, calendar and alarm state.
  logic [3:0]  tenths_q, tenths_d;
  logic [5:0]  second_q, second_d;
  logic [5:0]  minute_q, minute_d;
  logic [4:0]  hour_q, hour_d;
  logic [4:0]  day_q, day_d;
  logic [3:0]  month_q, month_d;
  logic [13:0] year_q, year_d;
  logic        leap_q, leap_d;
  logic        alarm_on_q, alarm_on_d;
  logic [5:0]  alarm_hour_q, alarm_hour_d;
  logic [5:0]  alarm_minute_q, alarm_minute_d;
  logic [5:0]  alarm_second_q, alarm_second_d;

  logic in_fire;
  logic advance;

  // The input register empties whenever the result register can take the
  // result, so a new beat can enter every cycle unless the master stalls.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // Tick cascade. Each wrap is decided on the current count, so the carry
  // chain is a set of parallel compares ANDed together.
  logic        tick_sec, tick_min, tick_hour, tick_day, tick_month, tick_year;
  logic [13:0] year_inc;
  logic        leap_inc;
  assign tick_sec   = (tenths_q >= LastTick);
  assign tick_min   = tick_sec && (second_q >= LAST_SECOND);
  assign tick_hour  = tick_min && (minute_q >= LAST_MINUTE);
  assign tick_day   = tick_hour && (hour_q >= LAST_HOUR);
  assign tick_month = tick_day && (day_q >= days_in(month_q, leap_q));
  assign tick_year  = tick_month && (month_q >= LAST_MONTH);
  assign year_inc   = (year_q >= TopYear) ? 14'd0 : (year_q + 14'd1);
  assign leap_inc   = is_leap(year_inc);

  // Validity of the set requests.
  logic time_ok, date_ok;
  assign time_ok = (in_q.second <= LAST_SECOND) && (in_q.minute <= LAST_MINUTE) &&
                   (in_q.hour <= LAST_HOUR);
  assign date_ok = (in_q.year <= TopYear) && (in_q.month <= LAST_MONTH) &&
                   (in_q.day != 5'd0) &&
                   (in_q.day <= days_in(in_q.month, is_leap(in_q.year)));

  // Alarm time: offset plus current time of day, with one correction per field.
  logic [6:0] sum_sec, sum_min;
  logic [5:0] sum_hour;
  logic [5:0] al_sec, al_min, al_hour;
  logic       carry_sec, carry_min;
  always_comb begin
    sum_sec   = 7'(in_q.second) + 7'(second_q);
    carry_sec = (sum_sec > 7'(LAST_SECOND));
    al_sec    = carry_sec ? 6'(sum_sec - 7'd60) : sum_sec[5:0];
    sum_min   = 7'(in_q.minute) + 7'(minute_q) + 7'(carry_sec);
    carry_min = (sum_min > 7'(LAST_MINUTE));
    al_min    = carry_min ? 6'(sum_min - 7'd60) : sum_min[5:0];
    sum_hour  = 6'(in_q.hour) + 6'(hour_q) + 6'(carry_min);
    al_hour   = (sum_hour > 6'(LAST_HOUR)) ? (sum_hour - 6'd24) : sum_hour;
  end

  // State update and result assembly for the item in the input register.
  logic accepted, fired;
  always_comb begin
    tenths_d       = tenths_q;
    second_d       = second_q;
    minute_d       = minute_q;
    hour_d         = hour_q;
    day_d          = day_q;
    month_d        = month_q;
    year_d         = year_q;
    leap_d         = leap_q;
    alarm_on_d     = alarm_on_q;
    alarm_hour_d   = alarm_hour_q;
    alarm_minute_d = alarm_minute_q;
    alarm_second_d = alarm_second_q;
    accepted       = 1'b1;
    fired          = 1'b0;

    unique case (in_q.op)
      OP_TICK: begin
        tenths_d = tick_sec   ? 4'd0 : (tenths_q + 4'd1);
        if (tick_sec) begin
          second_d = tick_min ? 6'd0 : (second_q + 6'd1);
        end
        if (tick_min) begin
          minute_d = tick_hour ? 6'd0 : (minute_q + 6'd1);
        end
        if (tick_hour) begin
          hour_d = tick_day ? 5'd0 : (hour_q + 5'd1);
        end
        if (tick_day) begin
          day_d = tick_month ? 5'd1 : (day_q + 5'd1);
        end
        if (tick_month) begin
          month_d = tick_year ? 4'd0 : (month_q + 4'd1);
        end
        if (tick_year) begin
          year_d = year_inc;
          leap_d = leap_inc;
        end
        // The alarm compares against the time after the tick.
        if (alarm_on_q && (6'(hour_d) == alarm_hour_q) &&
            (minute_d == alarm_minute_q) && (second_d == alarm_second_q)) begin
          fired          = 1'b1;
          alarm_on_d     = 1'b0;
          alarm_hour_d   = 6'd0;
          alarm_minute_d = 6'd0;
          alarm_second_d = 6'd0;
        end
      end
      OP_SET_TIME: begin
        accepted = time_ok;
        if (time_ok) begin
          tenths_d = 4'd0;
          second_d = in_q.second;
          minute_d = in_q.minute;
          hour_d   = in_q.hour;
        end
      end
      OP_SET_DATE: begin
        accepted = date_ok;
        if (date_ok) begin
          day_d   = in_q.day;
          month_d = in_q.month;
          year_d  = in_q.year;
          leap_d  = is_leap(in_q.year);
        end
      end
      OP_SET_ALARM: begin
        alarm_second_d = al_sec;
        alarm_minute_d = al_min;
        alarm_hour_d   = al_hour;
        alarm_on_d     = in_q.alarm_enable;
      end
      default: begin
        accepted = 1'b1;
      end
    endcase

    out_d = {1'b0, year_d, month_d, day_d, hour_d, minute_d, second_d, tenths_d,
             alarm_on_d, fired, accepted};
  end

  // Control and clock state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      tenths_q       <= 4'd0;
      second_q       <= 6'd0;
      minute_q       <= 6'd0;
      hour_q         <= 5'd0;
      day_q          <= 5'd1;
      month_q        <= 4'd0;
      year_q         <= 14'd2018;
      leap_q         <= 1'b0;
      alarm_on_q     <= 1'b0;
      alarm_hour_q   <= 6'd0;
      alarm_minute_q <= 6'd0;
      alarm_second_q <= 6'd0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        tenths_q       <= tenths_d;
        second_q       <= second_d;
        minute_q       <= minute_d;
        hour_q         <= hour_d;
        day_q          <= day_d;
        month_q        <= month_d;
        year_q         <= year_d;
        leap_q         <= leap_d;
        alarm_on_q     <= alarm_on_d;
        alarm_hour_q   <= alarm_hour_d;
        alarm_minute_q <= alarm_minute_d;
        alarm_second_q <= alarm_second_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q.op           <= op_e'(s_axis_tuser);
      in_q.hour         <= s_axis_tdata[4:0];
      in_q.minute       <= s_axis_tdata[10:5];
      in_q.second       <= s_axis_tdata[16:11];
      in_q.day          <= s_axis_tdata[21:17];
      in_q.month        <= s_axis_tdata[25:22];
      in_q.year         <= s_axis_tdata[39:26];
      in_q.alarm_enable <= s_axis_tdata[40];
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  // The clock state moves only when an item is processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(tenths_q) && $stable(second_q) && $stable(day_q) &&
                  $stable(year_q) && $stable(alarm_on_q)))
    else $error("clock state changed without a processed item");

  // Counters never leave their ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tenths_q <= LastTick) && (second_q <= LAST_SECOND) && (minute_q <= LAST_MINUTE) &&
    (hour_q <= LAST_HOUR) && (month_q <= LAST_MONTH) && (day_q != 5'd0) &&
    (day_q <= days_in(month_q, leap_q)))
    else $error("time or date counter out of range");

  // The leap flag always follows the stored year.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    leap_q == is_leap(year_q))
    else $error("leap flag disagrees with year");

  // A fired alarm is disarmed in the same result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
    else $error("alarm reported fired and still armed");

  // A processed item always lands in the result register on the next edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_q && (out_q == $past(out_d))))
    else $error("processed item lost on the way to the result register");

endmodule

`default_nettype wire
